@@ src/tcsal_pkg.sv @@
// Shared types and constants of the set-associative tile cache.
package tcsal_pkg;

	localparam int unsigned ZOOM_W  = 5;
	localparam int unsigned COORD_W = 24;
	localparam int unsigned STAMP_W = 32;
	localparam int unsigned SLOT_W  = 6;
	localparam int unsigned HASH_W  = 32;

	// Multiply-xor mix of the tile key.
	localparam logic [HASH_W-1:0] HASH_MUL_ZOOM = 32'h9e37_79b9;
	localparam logic [HASH_W-1:0] HASH_MUL_COL  = 32'h85eb_ca6b;
	localparam logic [HASH_W-1:0] HASH_MUL_ROW  = 32'hc2b2_ae35;
	localparam logic [HASH_W-1:0] HASH_MUL_FIN  = 32'h7feb_352d;
	localparam int unsigned       HASH_SHIFT_A  = 16;
	localparam int unsigned       HASH_SHIFT_B  = 15;

	typedef struct packed {
		logic [ZOOM_W-1:0]  zoom;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
	} key_t;

	typedef struct packed {
		key_t               key;
		logic [STAMP_W-1:0] stamp;
	} req_t;

	// One way of a set as it is stored in the set memory.
	typedef struct packed {
		logic               valid;
		key_t               key;
		logic [STAMP_W-1:0] stamp;
	} way_t;

	// Outcome of a lookup apart from the chosen way.
	typedef struct packed {
		logic hit;
		logic evicted;
		key_t ev_key;
	} sel_t;

	typedef enum logic {
		ST_CLEAR,
		ST_RUN
	} state_t;

endpackage

@@ src/tcsal_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module tcsal_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/tcsal_hash.sv @@
// Pipelined key hash and reduction of the hash to a set index.
module tcsal_hash #(
	parameter int unsigned SETS = 16,
	localparam int unsigned SW = (SETS > 1) ? $clog2(SETS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  tcsal_pkg::req_t   in_req,
	output logic              out_valid,
	output tcsal_pkg::req_t   out_req,
	output logic [SW-1:0]     out_set
);
	import tcsal_pkg::*;

	// Reciprocal of the set count; the estimate it gives is low by at most one.
	localparam logic [63:0]       RECIP_FULL = 64'h1_0000_0000 / SETS;
	localparam logic [HASH_W-1:0] RECIP      = RECIP_FULL[HASH_W-1:0];
	localparam logic [HASH_W-1:0] SETS_C     = HASH_W'(SETS);

	logic              valid_s1, valid_s2, valid_s3, valid_s4;
	req_t              req_s1, req_s2, req_s3, req_s4;
	logic [HASH_W-1:0] h_s1, h_s2, h_s3, q_s3, h_s4, qs_s4;

	logic [HASH_W-1:0] mz, mx, my, h1_mix, h2_mix, qs;
	logic [63:0]       qprod;
	logic [HASH_W-1:0] rem0, rem1;

	assign mz     = {{(HASH_W-ZOOM_W){1'b0}}, in_req.key.zoom} * HASH_MUL_ZOOM;
	assign mx     = {{(HASH_W-COORD_W){1'b0}}, in_req.key.col} * HASH_MUL_COL;
	assign my     = {{(HASH_W-COORD_W){1'b0}}, in_req.key.row} * HASH_MUL_ROW;
	assign h1_mix = h_s1 ^ (h_s1 >> HASH_SHIFT_A);
	assign h2_mix = h_s2 ^ (h_s2 >> HASH_SHIFT_B);
	assign qprod  = {32'd0, h2_mix} * {32'd0, RECIP};
	assign qs     = q_s3 * SETS_C;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		req_s1 <= in_req;
		h_s1   <= mz ^ mx ^ my;
		req_s2 <= req_s1;
		h_s2   <= h1_mix * HASH_MUL_FIN;
		req_s3 <= req_s2;
		h_s3   <= h2_mix;
		q_s3   <= qprod[63:32];
		req_s4 <= req_s3;
		h_s4   <= h_s3;
		qs_s4  <= qs;
	end

	// The remainder estimate lies below twice the set count.
	assign rem0 = h_s4 - qs_s4;
	assign rem1 = (rem0 >= SETS_C) ? (rem0 - SETS_C) : rem0;

	assign out_valid = valid_s4;
	assign out_req   = req_s4;
	assign out_set   = (SETS == 1) ? '0 : rem1[SW-1:0];

endmodule

@@ src/tcsal_way_sel.sv @@
// Hit detection, victim choice and row update for one set.
module tcsal_way_sel #(
	parameter int unsigned NW = 4,
	localparam int unsigned WW = (NW > 1) ? $clog2(NW) : 1
) (
	input  tcsal_pkg::way_t [NW-1:0] row,
	input  tcsal_pkg::req_t          req,
	output logic [WW-1:0]            way,
	output tcsal_pkg::sel_t          sel,
	output tcsal_pkg::way_t [NW-1:0] new_row
);
	import tcsal_pkg::*;

	localparam int unsigned LV = (NW > 1) ? $clog2(NW) : 0;
	localparam int unsigned NP = 1 << LV;

	logic               hit, have_empty;
	logic [WW-1:0]      hit_way, empty_way, lru_way;
	logic [STAMP_W-1:0] t_st [0:LV][0:NP-1];
	logic [WW-1:0]      t_ix [0:LV][0:NP-1];

	always_comb begin
		hit        = 1'b0;
		have_empty = 1'b0;
		hit_way    = '0;
		empty_way  = '0;
		for (int w = NW - 1; w >= 0; w--) begin
			if (row[w].valid && row[w].key == req.key) begin
				hit     = 1'b1;
				hit_way = WW'(w);
			end
			if (!row[w].valid) begin
				have_empty = 1'b1;
				empty_way  = WW'(w);
			end
		end
	end

	// Minimum-stamp tree; on a tie the lower way wins. Padding sits above the real ways.
	always_comb begin
		for (int l = 0; l <= LV; l++) begin
			for (int n = 0; n < NP; n++) begin
				t_st[l][n] = '1;
				t_ix[l][n] = '0;
			end
		end
		for (int n = 0; n < NW; n++) begin
			t_st[0][n] = row[n].stamp;
			t_ix[0][n] = WW'(n);
		end
		for (int n = NW; n < NP; n++) begin
			t_ix[0][n] = WW'(n);
		end
		for (int l = 0; l < LV; l++) begin
			for (int n = 0; n < (NP >> (l + 1)); n++) begin
				if (t_st[l][2*n+1] < t_st[l][2*n]) begin
					t_st[l+1][n] = t_st[l][2*n+1];
					t_ix[l+1][n] = t_ix[l][2*n+1];
				end else begin
					t_st[l+1][n] = t_st[l][2*n];
					t_ix[l+1][n] = t_ix[l][2*n];
				end
			end
		end
		lru_way = t_ix[LV][0];
	end

	always_comb begin
		priority if (hit) begin
			way = hit_way;
		end else if (have_empty) begin
			way = empty_way;
		end else begin
			way = lru_way;
		end
		sel.hit     = hit;
		sel.evicted = !hit && !have_empty;
		sel.ev_key  = sel.evicted ? row[way].key : '0;
		new_row     = row;
		new_row[way].stamp = req.stamp;
		if (!hit) begin
			new_row[way].valid = 1'b1;
			new_row[way].key   = req.key;
		end
	end

endmodule

@@ src/tile_cache_set_assoc_lru_core.sv @@
// Top level of the set-associative tile cache with least-recently-used replacement.
//
// A request word (zoom_level, tile_x, tile_y, frame_stamp) is taken at a rising
// edge where start is high and busy is low. The key is hashed and reduced to a
// set over four pipeline stages; the set row is then read from the set memory,
// checked for a hit, and the updated row is written back in the following cycle.
// The result word (hit, slot_index, evicted and the evicted key) appears on its
// ports for exactly one cycle with done high, after the hash stages, the lookup
// stage and the result register. The receiver cannot stall, so the result is
// never held. Requests are pipelined, but busy is high for the cycle after each
// accepted request, which spaces the set reads so that every read sees the
// write-back of the request before it. The read-modify-write on the single set
// memory sets this spacing.
// After reset the block runs a clearing pass that writes one empty set row per
// cycle, one for each of the CACHE_ENTRIES / WAYS sets (at least one); busy
// stays high during the pass. Evicted fields are zero on a hit and when an empty
// way is filled. slot_index is the set index times WAYS plus the way, kept to
// 6 bits.
module tile_cache_set_assoc_lru_core #(
	parameter int unsigned CACHE_ENTRIES = 64,
	parameter int unsigned WAYS          = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [tcsal_pkg::ZOOM_W-1:0]    zoom_level,
	input  logic [tcsal_pkg::COORD_W-1:0]   tile_x,
	input  logic [tcsal_pkg::COORD_W-1:0]   tile_y,
	input  logic [tcsal_pkg::STAMP_W-1:0]   frame_stamp,
	output logic                            done,
	output logic                            hit,
	output logic [tcsal_pkg::SLOT_W-1:0]    slot_index,
	output logic                            evicted,
	output logic [tcsal_pkg::ZOOM_W-1:0]    evicted_zoom,
	output logic [tcsal_pkg::COORD_W-1:0]   evicted_x,
	output logic [tcsal_pkg::COORD_W-1:0]   evicted_y
);
	import tcsal_pkg::*;

	// A set count of zero falls back to one set; ways beyond the entry count are dropped.
	localparam int unsigned SETS_RAW = CACHE_ENTRIES / WAYS;
	localparam int unsigned SETS     = (SETS_RAW == 0) ? 1 : SETS_RAW;
	localparam int unsigned SW       = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int unsigned NW       = (CACHE_ENTRIES < WAYS) ? CACHE_ENTRIES : WAYS;
	localparam int unsigned WW       = (NW > 1) ? $clog2(NW) : 1;
	localparam int unsigned ROW_W    = NW * $bits(way_t);

	// Control: clearing pass and request spacing.
	state_t        state_q, state_d;
	logic [SW-1:0] clr_idx_q, clr_idx_d;
	logic          clearing;
	logic          acc_q;
	logic          accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_idx_q <= '0;
			acc_q     <= 1'b0;
		end else begin
			state_q   <= state_d;
			clr_idx_q <= clr_idx_d;
			acc_q     <= accept;
		end
	end

	always_comb begin
		state_d   = state_q;
		clr_idx_d = clr_idx_q;
		clearing  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				clearing  = 1'b1;
				clr_idx_d = clr_idx_q + 1'b1;
				if (clr_idx_q == SW'(SETS - 1)) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				clr_idx_d = '0;
			end
		endcase
	end

	assign busy   = clearing | acc_q;
	assign accept = start & ~busy;

	// Hash and set reduction.
	req_t          in_req;
	logic          hs_valid;
	req_t          hs_req;
	logic [SW-1:0] hs_set;

	assign in_req.key.zoom = zoom_level;
	assign in_req.key.col  = tile_x;
	assign in_req.key.row  = tile_y;
	assign in_req.stamp    = frame_stamp;

	tcsal_hash #(
		.SETS (SETS)
	) u_hash (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.in_req    (in_req),
		.out_valid (hs_valid),
		.out_req   (hs_req),
		.out_set   (hs_set)
	);

	// The set row is read while the hashed request moves into the lookup stage.
	logic              valid_s5;
	logic [SW-1:0]     set_s5;
	logic [SLOT_W-1:0] base_s5;
	req_t              req_s5;
	logic [31:0]       base_full;

	assign base_full = 32'(hs_set) * 32'(WAYS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= hs_valid;
		end
	end

	always_ff @(posedge clk) begin
		set_s5  <= hs_set;
		base_s5 <= base_full[SLOT_W-1:0];
		req_s5  <= hs_req;
	end

	// Set memory: one row holds every way of a set, valid bits included.
	logic [ROW_W-1:0]  rd_data, wr_data;
	logic              ram_we;
	logic [SW-1:0]     ram_waddr;
	way_t [NW-1:0]     rd_row, new_row;
	logic [WW-1:0]     sel_way;
	sel_t              sel;

	assign rd_row    = rd_data;
	assign ram_we    = clearing | valid_s5;
	assign ram_waddr = clearing ? clr_idx_q : set_s5;
	assign wr_data   = clearing ? '0 : new_row;

	tcsal_ram #(
		.WIDTH (ROW_W),
		.DEPTH (SETS)
	) u_set_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_data),
		.raddr (hs_set),
		.rdata (rd_data)
	);

	tcsal_way_sel #(
		.NW (NW)
	) u_way_sel (
		.row     (rd_row),
		.req     (req_s5),
		.way     (sel_way),
		.sel     (sel),
		.new_row (new_row)
	);

	// Result register; the word is shown for one cycle with done high.
	logic              done_q;
	logic              hit_q, evicted_q;
	logic [SLOT_W-1:0] slot_q;
	key_t              ev_key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		hit_q     <= sel.hit;
		evicted_q <= sel.evicted;
		slot_q    <= base_s5 + SLOT_W'(sel_way);
		ev_key_q  <= sel.ev_key;
	end

	assign done         = done_q;
	assign hit          = hit_q;
	assign slot_index   = slot_q;
	assign evicted      = evicted_q;
	assign evicted_zoom = ev_key_q.zoom;
	assign evicted_x    = ev_key_q.col;
	assign evicted_y    = ev_key_q.row;

endmodule
